// ===== sv/mjw_pkg.sv =====
// Shared types and widths for the minimum-jerk waypoint pipeline.
package mjw_pkg;

    localparam int POS_W  = 24;          // Q3.20 position
    localparam int T_W    = 32;          // Q16.16 elapsed time
    localparam int TPM_W  = 16;          // time per meter register
    localparam int MAG_W  = 24;          // |target - current|
    localparam int SQ_W   = 2 * MAG_W;   // one squared delta
    localparam int RAD_W  = SQ_W + 2;    // sum of three squares
    localparam int DIST_W = RAD_W / 2;   // integer square root
    localparam int DUR_W  = DIST_W + TPM_W;
    localparam int S_W    = 29;          // normalized time, Q.24, below 32
    localparam int S2_W   = 2 * S_W - 24;
    localparam int S3_W   = S2_W + S_W - 24;
    localparam int Q_W    = 37;          // 6 s^2 - 15 s + 10, Q.24
    localparam int ACC_W  = S3_W + Q_W;  // wide product accumulator
    localparam int P_W    = 48;          // p(s), Q.24, saturating above
    localparam int DISP_W = MAG_W + P_W - 24;

    localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(100);

    // Per-item data carried alongside the arithmetic
    typedef struct packed {
        logic [2:0][POS_W-1:0] cur;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [T_W-1:0]        t;
    } t_side;

    // One result beat
    typedef struct packed {
        logic [2:0][POS_W-1:0] nxt;
        logic                  ovf;
    } t_res;

endpackage

// ===== sv/mjw_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module mjw_sqrt
    import mjw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [DIST_W-1:0] o_root,
    output t_side             o_side
);

    localparam int NS = DIST_W;
    localparam int RW = DIST_W + 3;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [RW-1:0]     rem;
        logic [DIST_W-1:0] root;
        t_side             side;
    } t_sq_stage;

    logic      r_v  [0:NS];
    t_sq_stage r_st [0:NS];

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= '{rad: i_rad, rem: '0, root: '0, side: i_side};
        end
    end

    // One root bit per stage: bring down two radicand bits, try root*4+1
    for (genvar k = 1; k <= NS; k++) begin : g_it
        logic [RW-1:0] cat;
        logic [RW-1:0] trial;
        t_sq_stage     n_st;

        always_comb begin
            cat   = {r_st[k-1].rem[RW-3:0], r_st[k-1].rad[RAD_W-1 -: 2]};
            trial = RW'({r_st[k-1].root, 2'b01});
            n_st  = r_st[k-1];
            n_st.rad = r_st[k-1].rad << 2;
            if (cat >= trial) begin
                n_st.rem  = cat - trial;
                n_st.root = {r_st[k-1].root[DIST_W-2:0], 1'b1};
            end else begin
                n_st.rem  = cat;
                n_st.root = {r_st[k-1].root[DIST_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_root  = r_st[NS].root;
    assign o_side  = r_st[NS].side;

endmodule

// ===== sv/mjw_div.sv =====
// Duration multiply and pipelined restoring division for normalized time.
module mjw_div
    import mjw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DIST_W-1:0] i_dist,
    input  logic [TPM_W-1:0]  i_tpm,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [S_W-1:0]    o_s,
    output logic              o_unb,
    output t_side             o_side
);

    localparam int NS = S_W + 2;

    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic [DUR_W-1:0] rem;
        logic [S_W-1:0]   q;
        logic             unb;
        t_side            side;
    } t_dv_stage;

    logic             r_v  [0:NS-1];
    t_dv_stage        r_st [0:NS-1];
    logic [DUR_W-1:0] n_dur;
    t_dv_stage        n_init;

    // Stage 0: duration = distance * time per meter
    always_comb begin
        n_dur = DUR_W'(i_dist) * DUR_W'(i_tpm);
    end

    // Stage 1: range check (s >= 32 iff t >= 2 * dur) and first partial remainder
    always_comb begin
        n_init     = r_st[0];
        n_init.unb = (r_st[0].dur == '0) ||
                     ((DUR_W+1)'(r_st[0].side.t) >= {r_st[0].dur, 1'b0});
        n_init.rem = DUR_W'(r_st[0].side.t[T_W-1:1]);
        n_init.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= '{dur: n_dur, rem: '0, q: '0, unb: 1'b0, side: i_side};
            r_st[1] <= n_init;
        end
    end

    // One quotient bit per stage; only the first step brings down a time bit
    for (genvar k = 2; k < NS; k++) begin : g_it
        logic [DUR_W:0] cat;
        t_dv_stage      n_st;

        always_comb begin
            cat  = {r_st[k-1].rem, (k == 2) ? r_st[k-1].side.t[0] : 1'b0};
            n_st = r_st[k-1];
            if (cat >= {1'b0, r_st[k-1].dur}) begin
                n_st.rem = DUR_W'(cat - {1'b0, r_st[k-1].dur});
                n_st.q   = {r_st[k-1].q[S_W-2:0], 1'b1};
            end else begin
                n_st.rem = cat[DUR_W-1:0];
                n_st.q   = {r_st[k-1].q[S_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_s     = r_st[NS-1].q;
    assign o_unb   = r_st[NS-1].unb;
    assign o_side  = r_st[NS-1].side;

endmodule

// ===== sv/mjw_poly.sv =====
// Quintic time scaling 10s^3 - 15s^4 + 6s^5 over a pipeline of multiply and truncation stages.
module mjw_poly
    import mjw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [S_W-1:0] i_s,
    input  logic           i_unb,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [P_W-1:0] o_p,
    output logic           o_unb,
    output t_side          o_side
);

    localparam int NS = 8;

    typedef struct packed {
        logic [S_W-1:0]   s;
        logic [2*S_W-1:0] m;
        logic [S2_W-1:0]  s2;
        logic [Q_W-1:0]   q;
        logic [S3_W-1:0]  s3;
        logic [ACC_W-1:0] a;
        logic [P_W-1:0]   p;
        logic             unb;
        t_side            side;
    } t_pl_stage;

    logic      r_v  [0:NS-1];
    t_pl_stage r_st [0:NS-1];
    t_pl_stage n_st [0:NS-1];

    always_comb begin
        logic [45:0]     pa;
        logic [45:0]     pb;
        logic [49:0]     pc;
        logic [49:0]     pd;
        logic [49:0]     pe;
        logic [Q_W-1:0]  pos;
        logic [Q_W-1:0]  neg;
        logic [S3_W-1:0] s3;

        // s * s
        n_st[0]      = '0;
        n_st[0].s    = i_s;
        n_st[0].unb  = i_unb;
        n_st[0].side = i_side;
        n_st[0].m    = i_s * i_s;

        // s2 truncated to Q.24
        n_st[1]    = r_st[0];
        n_st[1].s2 = r_st[0].m[2*S_W-1:24];

        // low half of s2 * s, and q = max(6 s2 + 10 - 15 s, 0)
        n_st[2]   = r_st[1];
        pa        = r_st[1].s2[16:0] * r_st[1].s;
        n_st[2].a = ACC_W'(pa);
        pos       = (Q_W'(r_st[1].s2) << 2) + (Q_W'(r_st[1].s2) << 1) + (Q_W'(10) << 24);
        neg       = (Q_W'(r_st[1].s) << 4) - Q_W'(r_st[1].s);
        n_st[2].q = (pos > neg) ? pos - neg : '0;

        // high half of s2 * s
        n_st[3]   = r_st[2];
        pb        = r_st[2].s2[S2_W-1:17] * r_st[2].s;
        n_st[3].a = r_st[2].a + (ACC_W'(pb) << 17);

        // s3 truncated, first 13-bit slice of s3 * q
        n_st[4]    = r_st[3];
        s3         = r_st[3].a[S3_W+23:24];
        n_st[4].s3 = s3;
        pc         = s3[12:0] * r_st[3].q;
        n_st[4].a  = ACC_W'(pc);

        // second slice
        n_st[5]   = r_st[4];
        pd        = r_st[4].s3[25:13] * r_st[4].q;
        n_st[5].a = r_st[4].a + (ACC_W'(pd) << 13);

        // third slice
        n_st[6]   = r_st[5];
        pe        = r_st[5].s3[S3_W-1:26] * r_st[5].q;
        n_st[6].a = r_st[5].a + (ACC_W'(pe) << 26);

        // p in Q.24; p >= 2^48 saturates every moving axis anyway
        n_st[7]     = r_st[6];
        n_st[7].p   = r_st[6].a[P_W+23:24];
        n_st[7].unb = r_st[6].unb | (|r_st[6].a[ACC_W-1:P_W+24]);
    end

    // Stage registers and valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_p     = r_st[NS-1].p;
    assign o_unb   = r_st[NS-1].unb;
    assign o_side  = r_st[NS-1].side;

endmodule

// ===== sv/mjw_skid.sv =====
// Output register with a skid entry so the pipeline stall is registered.
module mjw_skid
    import mjw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_res  i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_data
);

    logic r_main_v;
    logic r_skid_v;
    t_res r_main;
    t_res r_skid;

    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    // Valid flags: main drains into the output, skid catches a beat while main waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (i_ready || !r_main_v) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_valid;
            end
        end else if (i_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_main_v) begin
            r_main <= r_skid_v ? r_skid : i_data;
        end else if (i_valid && !r_skid_v) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== sv/min_jerk_waypoint.sv =====
// Order of registers: input, deltas, squares, sqrt, divider, poly, displacement, skid.
// Throughput: one beat per cycle unless held; the square root (26 stages) and divider
//   (31 stages) are fully pipelined; each multiply stage holds one partial product.
// The whole pipeline advances together; it holds only when the output skid is full.
// Reset: synchronous active low; clears all valid bits and sets time_per_meter to 100.
module min_jerk_waypoint
    import mjw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // cfg: time_per_meter
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TPM_W-1:0]     i_cfg_data,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // current_x, current_y, current_z, target_x, target_y, target_z, elapsed_time
    input  logic [175:0]         s_axis_tdata,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // next_x, next_y, next_z
    output logic [3*POS_W-1:0]   m_axis_tdata,
    // overflow
    output logic                 m_axis_tuser
);

    logic               en;
    logic [TPM_W-1:0]   r_tpm;

    logic               r_in_v;
    logic [175:0]       r_in_data;
    logic               r_a_v;
    t_side              r_a_side;
    t_side              n_a_side;
    logic               r_b_v;
    t_side              r_b_side;
    logic [2:0][SQ_W-1:0] r_b_sq;
    logic [2:0][SQ_W-1:0] n_b_sq;
    logic [RAD_W-1:0]   rad;

    logic               sq_v;
    logic [DIST_W-1:0]  sq_root;
    t_side              sq_side;
    logic               dv_v;
    logic [S_W-1:0]     dv_s;
    logic               dv_unb;
    t_side              dv_side;
    logic               pl_v;
    logic [P_W-1:0]     pl_p;
    logic               pl_unb;
    t_side              pl_side;

    logic                   r_l0_v;
    logic [2:0][SQ_W-1:0]   r_l0_d0;
    logic [2:0][SQ_W-1:0]   n_l0_d0;
    logic [P_W-25:0]        r_l0_phi;
    logic                   r_l0_unb;
    t_side                  r_l0_side;
    logic                   r_l1_v;
    logic [2:0][DISP_W-1:0] r_l1_disp;
    logic [2:0][DISP_W-1:0] n_l1_disp;
    logic                   r_l1_unb;
    t_side                  r_l1_side;
    t_res                   res;
    t_res                   out_res;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm <= TPM_RESET;
        end else if (i_cfg_valid) begin
            r_tpm <= i_cfg_data;
        end
    end

    assign s_axis_tready = en;

    // Valid bits of the input, delta, square and displacement registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_l0_v <= 1'b0;
            r_l1_v <= 1'b0;
        end else if (en) begin
            r_in_v <= s_axis_tvalid;
            r_a_v  <= r_in_v;
            r_b_v  <= r_a_v;
            r_l0_v <= pl_v;
            r_l1_v <= r_l0_v;
        end
    end

    // Deltas as magnitude and sign
    always_comb begin
        logic signed [POS_W:0] c;
        logic signed [POS_W:0] g;
        logic signed [POS_W:0] d;
        n_a_side   = '0;
        n_a_side.t = r_in_data[6*POS_W +: T_W];
        for (int i = 0; i < 3; i++) begin
            c = {r_in_data[i*POS_W + POS_W-1], r_in_data[i*POS_W +: POS_W]};
            g = {r_in_data[(i+3)*POS_W + POS_W-1], r_in_data[(i+3)*POS_W +: POS_W]};
            d = g - c;
            n_a_side.cur[i] = r_in_data[i*POS_W +: POS_W];
            n_a_side.neg[i] = d[POS_W];
            n_a_side.mag[i] = d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
        end
    end

    // Squares per axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_b_sq[i] = r_a_side.mag[i] * r_a_side.mag[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_data <= s_axis_tdata;
            r_a_side  <= n_a_side;
            r_b_sq    <= n_b_sq;
            r_b_side  <= r_a_side;
            r_l0_d0   <= n_l0_d0;
            r_l0_phi  <= pl_p[P_W-1:24];
            r_l0_unb  <= pl_unb;
            r_l0_side <= pl_side;
            r_l1_disp <= n_l1_disp;
            r_l1_unb  <= r_l0_unb;
            r_l1_side <= r_l0_side;
        end
    end

    assign rad = RAD_W'(r_b_sq[0]) + RAD_W'(r_b_sq[1]) + RAD_W'(r_b_sq[2]);

    mjw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_rad   (rad),
        .i_side  (r_b_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    mjw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_dist  (sq_root),
        .i_tpm   (r_tpm),
        .i_side  (sq_side),
        .o_valid (dv_v),
        .o_s     (dv_s),
        .o_unb   (dv_unb),
        .o_side  (dv_side)
    );

    mjw_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_v),
        .i_s     (dv_s),
        .i_unb   (dv_unb),
        .i_side  (dv_side),
        .o_valid (pl_v),
        .o_p     (pl_p),
        .o_unb   (pl_unb),
        .o_side  (pl_side)
    );

    // Displacement |delta| * p, low half of p first
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_l0_d0[i] = pl_side.mag[i] * pl_p[23:0];
        end
    end

    // High half, then drop the Q.24 fraction
    always_comb begin
        logic [SQ_W-1:0]      d1;
        logic [SQ_W+23:0]     full;
        for (int i = 0; i < 3; i++) begin
            d1   = r_l0_side.mag[i] * r_l0_phi;
            full = (SQ_W+24)'(r_l0_d0[i]) + {d1, 24'b0};
            n_l1_disp[i] = full[SQ_W+23:24];
        end
    end

    // Apply the displacement and saturate
    always_comb begin
        logic signed [DISP_W+1:0] w;
        logic signed [DISP_W+1:0] c;
        logic signed [DISP_W+1:0] dx;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            c  = {{(DISP_W+2-POS_W){r_l1_side.cur[i][POS_W-1]}}, r_l1_side.cur[i]};
            dx = {2'b00, r_l1_disp[i]};
            w  = r_l1_side.neg[i] ? c - dx : c + dx;
            if (r_l1_side.mag[i] == '0) begin
                res.nxt[i] = r_l1_side.cur[i];
            end else if (r_l1_unb) begin
                res.nxt[i] = r_l1_side.neg[i] ? {1'b1, {(POS_W-1){1'b0}}}
                                              : {1'b0, {(POS_W-1){1'b1}}};
                res.ovf    = 1'b1;
            end else if (w > $signed({{(DISP_W+3-POS_W){1'b0}}, {(POS_W-1){1'b1}}})) begin
                res.nxt[i] = {1'b0, {(POS_W-1){1'b1}}};
                res.ovf    = 1'b1;
            end else if (w < $signed({{(DISP_W+3-POS_W){1'b1}}, {(POS_W-1){1'b0}}})) begin
                res.nxt[i] = {1'b1, {(POS_W-1){1'b0}}};
                res.ovf    = 1'b1;
            end else begin
                res.nxt[i] = w[POS_W-1:0];
            end
        end
    end

    mjw_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_l1_v),
        .o_ready (en),
        .i_data  (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = out_res.nxt;
    assign m_axis_tuser = out_res.ovf;

endmodule

// ===== tb/min_jerk_waypoint_tb.sv =====
// Self-checking testbench for the minimum-jerk waypoint pipeline.
module min_jerk_waypoint_tb;
    import mjw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] PMAX = 24'h7FFFFF;
    localparam logic [23:0] PMIN = 24'h800000;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic [2:0][23:0] cur;
        logic [2:0][23:0] tgt;
        logic [31:0]      t;
        bit               typed;
        t_res             res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [TPM_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [175:0]         s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [3*POS_W-1:0]   m_axis_tdata;
    logic                 m_axis_tuser;

    t_res             pending_waypoints[$];
    longint unsigned  tpm_model = 100;
    int               src_idle_pct = 0;
    int               snk_stall_pct = 0;
    int               mismatches = 0;
    int               beats_in = 0;
    int               beats_out = 0;
    int               ovf_seen = 0;
    int               cycles = 0;
    t_row             rows[$];

    min_jerk_waypoint dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // floor(a * b / 2^24), same split as the hardware product
    function automatic longint unsigned mulq24(longint unsigned a, longint unsigned b);
        return a * (b >> 24) + ((a * (b & 64'hFFFFFF)) >> 24);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned distance_q20(logic [2:0][23:0] c, logic [2:0][23:0] g);
        longint unsigned sumsq, m;
        longint d;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            d = longint'($signed(g[i])) - longint'($signed(c[i]));
            m = (d < 0) ? -d : d;
            sumsq += m * m;
        end
        return isqrt(sumsq);
    endfunction

    // Expected waypoint for one request at the given time-per-meter
    function automatic t_res predict_waypoint(logic [2:0][23:0] c, logic [2:0][23:0] g,
                                              logic [31:0] t, longint unsigned tpm);
        t_res r;
        longint unsigned len, dur, s, s2, s3, pos, neg, q, p, m;
        longint d, v;
        bit unb;
        p = 0;
        unb = 0;
        r.ovf = 1'b0;
        len = distance_q20(c, g);
        dur = len * tpm;
        if (len != 0) begin
            if (dur == 0) begin
                unb = 1;
            end else begin
                s = ({32'd0, t} << 28) / dur;
                if (s >= (64'd1 << 29)) begin
                    unb = 1;
                end else begin
                    s2 = mulq24(s, s);
                    s3 = mulq24(s2, s);
                    pos = 6 * s2 + 10 * (64'd1 << 24);
                    neg = 15 * s;
                    q = (pos > neg) ? pos - neg : 0;
                    p = mulq24(s3, q);
                    if (p >= (64'd1 << 49)) unb = 1;
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            d = longint'($signed(g[i])) - longint'($signed(c[i]));
            v = longint'($signed(c[i]));
            if (d != 0) begin
                if (unb) begin
                    v = (d > 0) ? 64'sd8388608 : -64'sd8388609;
                end else begin
                    m = (d < 0) ? -d : d;
                    v = (d < 0) ? v - longint'(mulq24(m, p)) : v + longint'(mulq24(m, p));
                end
            end
            if (v > 64'sd8388607) begin
                v = 64'sd8388607;
                r.ovf = 1'b1;
            end else if (v < -64'sd8388608) begin
                v = -64'sd8388608;
                r.ovf = 1'b1;
            end
            r.nxt[i] = v[23:0];
        end
        return r;
    endfunction

    // Result beat check against the oldest pending waypoint
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (m_axis_tuser) ovf_seen++;
            if (pending_waypoints.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: next=%h ovf=%b", m_axis_tdata, m_axis_tuser);
            end else begin
                e = pending_waypoints.pop_front();
                if (m_axis_tdata !== e.nxt || m_axis_tuser !== e.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch beat %0d: exp next=%h ovf=%b got next=%h ovf=%b",
                                 beats_out, e.nxt, e.ovf, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // One request beat with optional idle gap in front
    task automatic send_request(logic [2:0][23:0] c, logic [2:0][23:0] g, logic [31:0] t,
                                bit typed, t_res res);
        t_res pr;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, g[2], g[1], g[0], c[2], c[1], c[0]};
        do @(posedge i_clk); while (!s_axis_tready);
        pr = predict_waypoint(c, g, t, tpm_model);
        if (typed && (pr.nxt !== res.nxt || pr.ovf !== res.ovf))
            $display("note: typed row differs from predictor");
        pending_waypoints.push_back(typed ? res : pr);
        beats_in++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_waypoints.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tpm(logic [15:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tpm_model = 64'(v);
    endtask

    function automatic void add_row(logic [2:0][23:0] c, logic [2:0][23:0] g, logic [31:0] t,
                                    bit typed, logic [2:0][23:0] n, logic o);
        t_row r;
        r.cur = c;
        r.tgt = g;
        r.t = t;
        r.typed = typed;
        r.res.nxt = n;
        r.res.ovf = o;
        rows.push_back(r);
    endfunction

    // Random request: mostly moves with time near the motion window
    task automatic random_request();
        logic [2:0][23:0] c, g;
        logic [31:0] t;
        longint unsigned dur, tt;
        int shift;
        t_res none;
        none = '0;
        for (int i = 0; i < 3; i++) begin
            c[i] = 24'($urandom);
            shift = $urandom_range(23, 0);
            g[i] = ($urandom_range(3) == 0) ? c[i] : c[i] + 24'(($urandom << 8) >>> shift);
        end
        if ($urandom_range(9) < 7) begin
            dur = distance_q20(c, g) * tpm_model;
            tt = (dur / 16) * $urandom_range(130) / 100;
            t = (tt > 64'hFFFFFFFF) ? 32'hFFFFFFFF : tt[31:0];
        end else if ($urandom_range(1)) begin
            t = $urandom;
            for (int i = 0; i < 3; i++) g[i] = 24'($urandom);
        end else begin
            t = $urandom >> $urandom_range(31);
        end
        send_request(c, g, t, 1'b0, none);
    endtask

    initial begin
        logic [2:0][23:0] z3;
        z3 = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset value 100
        add_row('{24'd123, PMIN, PMAX}, '{24'd123, PMIN, PMAX}, 32'h12345678, 1,
                '{24'd123, PMIN, PMAX}, 1'b0);
        add_row(z3, '{PMAX, PMIN, PMAX}, 32'd0, 1, z3, 1'b0);
        add_row(z3, '{24'd0, PMIN, PMAX}, 32'hFFFFFFFF, 1, '{24'd0, PMIN, PMAX}, 1'b1);
        add_row('{PMIN, PMIN, PMIN}, '{PMAX, PMAX, PMAX}, 32'hFFFFFFFF, 1,
                '{PMAX, PMAX, PMAX}, 1'b1);
        add_row('{PMAX, PMAX, PMAX}, '{PMIN, PMIN, PMIN}, 32'hFFFFFFFF, 1,
                '{PMIN, PMIN, PMIN}, 1'b1);
        add_row(z3, '{24'd0, 24'd0, 24'h100000}, 32'd3276800, 0, z3, 1'b0);
        add_row(z3, '{24'd0, 24'd0, 24'h100000}, 32'd6553600, 0, z3, 1'b0);
        add_row(z3, '{24'd0, 24'd0, 24'h100000}, 32'd7864320, 0, z3, 1'b0);
        add_row(z3, '{24'd0, 24'd0, PMAX}, 32'd78643190, 0, z3, 1'b0);
        add_row(z3, '{24'd0, 24'd0, PMIN}, 32'd78643190, 0, z3, 1'b0);
        add_row('{24'h0F0F0F, 24'hF0F0F0, 24'h555555}, '{24'hAAAAAA, 24'h333333, 24'hCCCCCC},
                32'h0A5A5A5A, 0, z3, 1'b0);
        add_row('{24'h000001, 24'hFFFFFF, 24'h7FFFFE}, '{24'h000002, 24'hFFFFFE, 24'h7FFFFF},
                32'h00000001, 0, z3, 1'b0);
        add_row('{24'h400000, 24'hC00000, 24'h000000}, '{24'h400000, 24'h400000, 24'hC00000},
                32'h80000000, 0, z3, 1'b0);
        foreach (rows[k]) send_request(rows[k].cur, rows[k].tgt, rows[k].t,
                                       rows[k].typed, rows[k].res);

        // random phases across settings and idling patterns
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_tpm(16'd1);     src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin write_tpm(16'd65535); src_idle_pct = 51; snk_stall_pct = 0;  end
                2: begin write_tpm(16'($urandom_range(65534, 2))); src_idle_pct = 0;
                         snk_stall_pct = 51; end
                3: begin write_tpm(16'd37);    src_idle_pct = 8;  snk_stall_pct = 8;  end
                4: begin write_tpm(16'($urandom_range(300, 2))); src_idle_pct = 51;
                         snk_stall_pct = 51; end
                default: begin write_tpm(16'd100); src_idle_pct = 0; snk_stall_pct = 0; end
            endcase
            for (int n = 0; n < 200; n++) begin
                // sender hold-off until the pipeline has emptied
                if (ph == 5 && n == 100) drain_results();
                random_request();
            end
        end

        drain_results();
        $display("run covered %0d requests, %0d results (%0d saturated), 7 register settings",
                 beats_in, beats_out, ovf_seen);
        if (mismatches == 0 && pending_waypoints.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
